>>> hdl/group_membership_table_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GROUP_MEMBERSHIP_TABLE_CORE_MACROS_SVH
`define GROUP_MEMBERSHIP_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define GMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gmt_pkg.sv
// ----------------------------------------------------------------------------
// Group membership table package
// Opcodes, field layout of the stream beats and memory control struct.
// ----------------------------------------------------------------------------
package gmt_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_ADD    = 2'd1,
    OP_QUERY  = 2'd2
  } gmt_op_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // input beat fields
  localparam int OP_W   = 2;
  localparam int GRP_W  = 6;
  localparam int ID_W   = 32;
  localparam int OP_LSB  = 0;
  localparam int GRP_LSB = OP_LSB + OP_W;
  localparam int ID_LSB  = GRP_LSB + GRP_W;
  localparam int IN_W    = 40;

  // result beat fields
  localparam int NEWG_W  = 6;
  localparam int TOTAL_W = 6;
  localparam int ISO_W   = 11;
  localparam int STATUS_LSB = 0;
  localparam int NEWG_LSB   = 1;
  localparam int FOUND_LSB  = NEWG_LSB + NEWG_W;
  localparam int TOTAL_LSB  = FOUND_LSB + 1;
  localparam int ISO_LSB    = TOTAL_LSB + TOTAL_W;
  localparam int OUT_USED   = ISO_LSB + ISO_W;
  localparam int OUT_W      = 32;
  localparam int OUT_PAD    = OUT_W - OUT_USED;

  typedef struct packed {
    logic fill_we;
    logic fill_re;
    logic store_we;
    logic store_re;
  } gmt_mem_ctl_t;

endpackage

>>> hdl/gmt_mem.sv
// ----------------------------------------------------------------------------
// Group membership table memories
// Fill count per group and member id store, each with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module gmt_mem
  import gmt_pkg::*;
#(
  parameter int MAX_GROUPS  = 32,
  parameter int MAX_MEMBERS = 64,
  localparam int SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
  localparam int FW = $clog2(MAX_MEMBERS + 1),
  localparam int AW = (MAX_GROUPS * MAX_MEMBERS > 1) ? $clog2(MAX_GROUPS * MAX_MEMBERS) : 1
) (
  input  logic             clk,
  input  gmt_mem_ctl_t     mem_ctl,
  input  logic [SW-1:0]    fill_waddr,
  input  logic [FW-1:0]    fill_wdata,
  input  logic [SW-1:0]    fill_raddr,
  output logic [FW-1:0]    fill_rdata,
  input  logic [AW-1:0]    store_waddr,
  input  logic [ID_W-1:0]  store_wdata,
  input  logic [AW-1:0]    store_raddr,
  output logic [ID_W-1:0]  store_rdata
);

  logic [FW-1:0]   fill_mem  [MAX_GROUPS];
  logic [ID_W-1:0] store_mem [MAX_GROUPS * MAX_MEMBERS];

  always_ff @(posedge clk) begin
    if (mem_ctl.fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (mem_ctl.fill_re) begin
      fill_rdata <= fill_mem[fill_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    if (mem_ctl.store_re) begin
      store_rdata <= store_mem[store_raddr];
    end
  end

endmodule

>>> hdl/gmt_ctrl.sv
// ----------------------------------------------------------------------------
// Group membership table controller
// Decodes one beat at a time, updates the counters and memories and scans a
// group's member list one stored id per cycle for a query.
// ----------------------------------------------------------------------------
module gmt_ctrl
  import gmt_pkg::*;
#(
  parameter int MAX_GROUPS  = 32,
  parameter int MAX_MEMBERS = 64,
  localparam int CW = $clog2(MAX_GROUPS + 1),
  localparam int SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
  localparam int FW = $clog2(MAX_MEMBERS + 1),
  localparam int AW = (MAX_GROUPS * MAX_MEMBERS > 1) ? $clog2(MAX_GROUPS * MAX_MEMBERS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output gmt_mem_ctl_t      mem_ctl,
  output logic [SW-1:0]     fill_waddr,
  output logic [FW-1:0]     fill_wdata,
  output logic [SW-1:0]     fill_raddr,
  input  logic [FW-1:0]     fill_rdata,
  output logic [AW-1:0]     store_waddr,
  output logic [ID_W-1:0]   store_wdata,
  output logic [AW-1:0]     store_raddr,
  input  logic [ID_W-1:0]   store_rdata
);

  localparam int CMPW = (CW > GRP_W) ? CW : GRP_W;
  localparam logic [CW-1:0] MAXG_C = CW'(MAX_GROUPS);
  localparam logic [FW-1:0] MAXM_C = FW'(MAX_MEMBERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t              state_r;
  gmt_op_t             op_r;
  logic [ID_W-1:0]     id_r;
  logic [SW-1:0]       slot_r;
  logic                gvalid_r;
  logic [CW-1:0]       cnt_r;
  logic [ISO_W-1:0]    add_r;
  logic [FW-1:0]       n_r;
  logic [FW-1:0]       idx_r;
  logic                pend_r;
  logic                status_r;
  logic [NEWG_W-1:0]   newg_r;
  logic                found_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic [OP_W-1:0]     in_op;
  logic [GRP_W-1:0]    in_grp;
  logic [ID_W-1:0]     in_id;
  logic [SW-1:0]       in_slot;
  logic                grp_ok;
  logic                create_ok;
  logic                add_ok;
  logic                hit;
  logic                scan_end;
  logic                out_load;

  function automatic logic [AW-1:0] entry_addr(logic [SW-1:0] s, logic [FW-1:0] i);
    return AW'(s) * AW'(MAX_MEMBERS) + AW'(i);
  endfunction

  assign in_op   = in_tdata[OP_LSB +: OP_W];
  assign in_grp  = in_tdata[GRP_LSB +: GRP_W];
  assign in_id   = in_tdata[ID_LSB +: ID_W];
  assign in_slot = SW'(CMPW'(in_grp) - CMPW'(1));
  assign grp_ok  = (in_grp != '0) && (CMPW'(in_grp) <= CMPW'(cnt_r));

  assign create_ok = cnt_r < MAXG_C;
  assign add_ok    = gvalid_r && (fill_rdata < MAXM_C);
  assign hit       = pend_r && (store_rdata == id_r);
  assign scan_end  = hit || (idx_r == n_r);
  assign out_load  = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    mem_ctl     = '0;
    fill_waddr  = slot_r;
    fill_wdata  = FW'(fill_rdata + FW'(1));
    fill_raddr  = in_slot;
    store_waddr = entry_addr(slot_r, fill_rdata);
    store_wdata = id_r;
    store_raddr = entry_addr(slot_r, idx_r);
    unique case (state_r)
      ST_IDLE: begin
        mem_ctl.fill_re = in_tvalid;
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_CREATE: begin
            if (create_ok) begin
              // owner becomes the first member of the new slot
              mem_ctl.fill_we  = 1'b1;
              mem_ctl.store_we = 1'b1;
              fill_waddr       = SW'(cnt_r);
              fill_wdata       = FW'(1);
              store_waddr      = entry_addr(SW'(cnt_r), '0);
            end
          end
          OP_ADD: begin
            if (add_ok) begin
              mem_ctl.fill_we  = 1'b1;
              mem_ctl.store_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        mem_ctl.store_re = !scan_end;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      add_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r     <= gmt_op_t'(in_op);
            id_r     <= in_id;
            slot_r   <= in_slot;
            gvalid_r <= grp_ok;
            status_r <= STATUS_ERR;
            newg_r   <= '0;
            found_r  <= 1'b0;
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= ST_RESP;
          unique case (op_r)
            OP_CREATE: begin
              if (create_ok) begin
                cnt_r    <= CW'(cnt_r + CW'(1));
                newg_r   <= NEWG_W'(cnt_r + CW'(1));
                status_r <= STATUS_OK;
              end
            end
            OP_ADD: begin
              if (add_ok) begin
                add_r    <= ISO_W'(add_r + ISO_W'(1));
                status_r <= STATUS_OK;
              end
            end
            OP_QUERY: begin
              if (gvalid_r) begin
                n_r     <= fill_rdata;
                idx_r   <= '0;
                pend_r  <= 1'b0;
                state_r <= ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          // one read in flight; stop on a match or once the list is exhausted
          pend_r <= !scan_end;
          if (!scan_end) begin
            idx_r <= FW'(idx_r + FW'(1));
          end else begin
            found_r  <= hit;
            status_r <= STATUS_OK;
            state_r  <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            out_data_r <= {{OUT_PAD{1'b0}}, add_r, TOTAL_W'(cnt_r), found_r, newg_r,
                           status_r};
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/group_membership_table_core.sv
// ----------------------------------------------------------------------------
// Group membership table core
// Up to MAX_GROUPS groups of up to MAX_MEMBERS member ids, with create, add
// and query operations over a stream interface.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Create, add and an invalid request pass from
// acceptance to the result register through decode with the fill count
// read, execute and load result. A query scans at most the members its group
// holds and stops early when the id is found: the member memory has one read
// port and the scan reads one stored id per cycle. A result waiting in the
// output register does not stop the next beat from being accepted; only its
// own result load waits for it.
// Memory contents need no clearing after reset: a fill count is used only
// for a created group and a stored id only below its group's fill count.
`include "group_membership_table_core_macros.svh"

module group_membership_table_core
  import gmt_pkg::*;
#(
  parameter int MAX_GROUPS  = 32,
  parameter int MAX_MEMBERS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // opcode[1:0], group_number[7:2], member_id[39:8]
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[0], new_group[6:1], found[7], group_total[13:8],
  // isolation_count[24:14], zero pad[31:25]
  output logic [OUT_W-1:0]  out_tdata
);

  localparam int SW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int FW = $clog2(MAX_MEMBERS + 1);
  localparam int AW = (MAX_GROUPS * MAX_MEMBERS > 1) ? $clog2(MAX_GROUPS * MAX_MEMBERS) : 1;

  gmt_mem_ctl_t     mem_ctl;
  logic [SW-1:0]    fill_waddr;
  logic [FW-1:0]    fill_wdata;
  logic [SW-1:0]    fill_raddr;
  logic [FW-1:0]    fill_rdata;
  logic [AW-1:0]    store_waddr;
  logic [ID_W-1:0]  store_wdata;
  logic [AW-1:0]    store_raddr;
  logic [ID_W-1:0]  store_rdata;

  gmt_ctrl #(
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mem_ctl     (mem_ctl),
    .fill_waddr  (fill_waddr),
    .fill_wdata  (fill_wdata),
    .fill_raddr  (fill_raddr),
    .fill_rdata  (fill_rdata),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata)
  );

  gmt_mem #(
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_mem (
    .clk         (clk),
    .mem_ctl     (mem_ctl),
    .fill_waddr  (fill_waddr),
    .fill_wdata  (fill_wdata),
    .fill_raddr  (fill_raddr),
    .fill_rdata  (fill_rdata),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata)
  );

  // one request in flight: no second beat right behind an accepted one
  `GMT_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "beat accepted back to back")
  // memory writes only while a request is being executed
  `GMT_ASSERT_IMP(a_write_busy, mem_ctl.fill_we || mem_ctl.store_we, !in_tready && !mem_ctl.store_re, "memory write outside execute")
  // a hit only comes from a successful query, which creates nothing
  `GMT_ASSERT_IMP(a_found_ok, out_tvalid && out_tdata[FOUND_LSB], !out_tdata[STATUS_LSB] && (out_tdata[FOUND_LSB-1:NEWG_LSB] == '0), "found set on non-query result")

endmodule
